// ===== src/psu_pkg.sv =====
package psu_pkg;

   // Line store depth default and fixed field widths
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int CFG_DATA_W        = 16;
   localparam int CFG_INDEX_W       = 2;
   localparam int HEIGHT_W          = 16;
   localparam int IMG_WIDTH_W       = 13;
   localparam int COMP_W            = 3;

   // Register indexes
   localparam logic [CFG_INDEX_W-1:0] REG_COLOR_COMPONENTS = 2'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH      = 2'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT     = 2'd2;

   localparam logic [COMP_W-1:0] COMP_RGBA = 3'd4;

   // Filter type codes
   localparam logic [2:0] FILT_NONE    = 3'd0;
   localparam logic [2:0] FILT_SUB     = 3'd1;
   localparam logic [2:0] FILT_UP      = 3'd2;
   localparam logic [2:0] FILT_AVERAGE = 3'd3;
   localparam logic [2:0] FILT_PAETH   = 3'd4;

   typedef logic [31:0] pixel_type;

   // Neighbors and filtered pixel handed to the reconstruction lanes
   typedef struct packed {
      logic [2:0] filter;
      logic       rgba;
      pixel_type  filtered;
      pixel_type  left;
      pixel_type  upper;
      pixel_type  upper_left;
   } recon_req_type;

   // Paeth predictor on one byte lane
   function automatic logic [7:0] paeth_byte(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] pa_s;
      logic signed [10:0] pb_s;
      logic signed [10:0] pc_s;
      logic [9:0]         pa;
      logic [9:0]         pb;
      logic [9:0]         pc;
      pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
      pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
      pc_s = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
      pa = pa_s[10] ? 10'(-pa_s) : pa_s[9:0];
      pb = pb_s[10] ? 10'(-pb_s) : pb_s[9:0];
      pc = pc_s[10] ? 10'(-pc_s) : pc_s[9:0];
      if (pa <= pb && pa <= pc) begin
         paeth_byte = a;
      end else if (pb <= pc) begin
         paeth_byte = b;
      end else begin
         paeth_byte = c;
      end
   endfunction

endpackage

// ===== src/psu_line_store.sv =====
module psu_line_store #(
   parameter int DEPTH = psu_pkg::MAX_WIDTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output psu_pkg::pixel_type rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  psu_pkg::pixel_type wr_data
);
   import psu_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/psu_recon.sv =====
module psu_recon (
   input  psu_pkg::recon_req_type req,
   output psu_pkg::pixel_type     recon
);
   import psu_pkg::*;

   // Predict and add per byte lane
   always_comb begin
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] pred;
      logic [8:0] sum_ab;
      recon = '0;
      for (int i = 0; i < 4; i++) begin
         a      = req.left[8*i +: 8];
         b      = req.upper[8*i +: 8];
         c      = req.upper_left[8*i +: 8];
         sum_ab = {1'b0, a} + {1'b0, b};
         unique case (req.filter)
            FILT_SUB:     pred = a;
            FILT_UP:      pred = b;
            FILT_AVERAGE: pred = sum_ab[8:1];
            FILT_PAETH:   pred = paeth_byte(a, b, c);
            default:      pred = 8'd0;
         endcase
         recon[8*i +: 8] = req.filtered[8*i +: 8] + pred;
      end
      // Drop alpha for three components
      if (!req.rgba) begin
         recon[31:24] = 8'd0;
      end
   end

endmodule

// ===== src/png_scanline_unfilter.sv =====
// PNG scanline unfilter, filter method 0, 8-bit RGB or RGBA.
// Input channel req_*: one filtered pixel per item with its row's filter
// type. Result channel rsp_*: the reconstructed pixel with row_end,
// image_end and bad_filter flags. Both channels use valid/stall.
// Configuration: csr_write_enable, csr_index, csr_write_data; write only
// while the block is idle. Index 0 components, 1 width, 2 height.
// An accepted item is held in the read stage, beside the line store read,
// then reconstructed into the output register. Throughput: one item per
// cycle while the receiver does not stall, set by the line store's
// separate read and write ports, with the write of a column forwarded
// to a read of the same column in the same cycle.
// When the receiver stalls, the output register holds and the stage in
// front of it fills; req_stall then rises until the output moves.
// Reset clears counters, pipeline valids and registers to 3 components,
// width 1, height 1. The line store needs no clearing: the first row of
// each image ignores it.
module png_scanline_unfilter #(
   parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [psu_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [psu_pkg::CFG_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_filter_type,
   input  logic [7:0]                      req_red_filtered,
   input  logic [7:0]                      req_green_filtered,
   input  logic [7:0]                      req_blue_filtered,
   input  logic [7:0]                      req_alpha_filtered,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_blue,
   output logic [7:0]                      rsp_alpha,
   output logic                            rsp_row_end,
   output logic                            rsp_image_end,
   output logic                            rsp_bad_filter
);
   import psu_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = (IMG_WIDTH_W + 1 > AW + 1) ? IMG_WIDTH_W + 1 : AW + 1;
   localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

   // Configuration registers
   logic [COMP_W-1:0]      comp_ff;
   logic [IMG_WIDTH_W-1:0] width_ff;
   logic [HEIGHT_W-1:0]    height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff   <= 3'd3;
         width_ff  <= 13'd1;
         height_ff <= 16'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_COLOR_COMPONENTS: comp_ff   <= csr_write_data[COMP_W-1:0];
            REG_IMAGE_WIDTH:      width_ff  <= csr_write_data[IMG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:     height_ff <= csr_write_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective width and height
   logic [EW-1:0]       width_raw;
   logic [EW-1:0]       width_eff;
   logic [HEIGHT_W-1:0] height_eff;

   always_comb begin
      width_raw = EW'(width_ff);
      if (width_raw == '0) begin
         width_eff = EW'(1);
      end else if (width_raw > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = width_raw;
      end
      height_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   end

   // Counters and pipeline registers
   logic [AW-1:0]       col_cnt_ff;
   logic [AW-1:0]       col_cnt_in;
   logic [HEIGHT_W-1:0] row_cnt_ff;
   logic [HEIGHT_W-1:0] row_cnt_in;

   logic                s1_valid_ff;
   logic [AW-1:0]       s1_col_ff;
   logic [2:0]          s1_filter_ff;
   logic                s1_rgba_ff;
   pixel_type           s1_pixel_ff;
   logic                s1_col0_ff;
   logic                s1_row0_ff;
   logic                s1_row_end_ff;
   logic                s1_image_end_ff;
   logic                s1_fwd_ff;

   pixel_type           prev_recon_ff;
   pixel_type           prev_upper_ff;

   logic                rsp_valid_ff;
   pixel_type           rsp_pixel_ff;
   logic                rsp_row_end_ff;
   logic                rsp_image_end_ff;
   logic                rsp_bad_ff;

   // Handshake
   logic out_free;
   logic s1_move;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Position of the incoming item
   logic [EW-1:0] col_wide;
   logic [EW-1:0] col_next_wide;
   logic [AW-1:0] col_addr;
   logic          row_end;
   logic          image_end;
   logic [16:0]   row_next_wide;

   always_comb begin
      col_wide      = EW'(col_cnt_ff);
      col_next_wide = col_wide + EW'(1);
      if (col_wide >= width_eff) begin
         col_addr = AW'(width_eff - EW'(1));
      end else begin
         col_addr = col_cnt_ff;
      end
      row_end       = col_next_wide >= width_eff;
      row_next_wide = {1'b0, row_cnt_ff} + 17'd1;
      image_end     = row_end && (row_next_wide >= {1'b0, height_eff});
      if (row_end) begin
         col_cnt_in = '0;
         row_cnt_in = image_end ? '0 : row_next_wide[HEIGHT_W-1:0];
      end else begin
         col_cnt_in = AW'(col_next_wide);
         row_cnt_in = row_cnt_ff;
      end
   end

   // Advance counters on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // Line store
   pixel_type rd_data;
   pixel_type recon;

   psu_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (rd_data),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (recon)
   );

   // Load the read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff       <= col_addr;
         s1_filter_ff    <= req_filter_type;
         s1_rgba_ff      <= (comp_ff == COMP_RGBA);
         s1_pixel_ff     <= {req_alpha_filtered, req_blue_filtered,
                             req_green_filtered, req_red_filtered};
         s1_col0_ff      <= (col_cnt_ff == '0);
         s1_row0_ff      <= (row_cnt_ff == '0);
         s1_row_end_ff   <= row_end;
         s1_image_end_ff <= image_end;
         s1_fwd_ff       <= s1_move && (s1_col_ff == col_addr);
      end
   end

   // Select neighbors, forwarding a same-column write
   recon_req_type rreq;
   pixel_type     upper;

   always_comb begin
      if (s1_row0_ff) begin
         upper = '0;
      end else if (s1_fwd_ff) begin
         upper = prev_recon_ff;
      end else begin
         upper = rd_data;
      end
      rreq.filter     = s1_filter_ff;
      rreq.rgba       = s1_rgba_ff;
      rreq.filtered   = s1_pixel_ff;
      rreq.upper      = upper;
      rreq.left       = s1_col0_ff ? '0 : prev_recon_ff;
      rreq.upper_left = s1_col0_ff ? '0 : prev_upper_ff;
   end

   psu_recon u_recon (
      .req   (rreq),
      .recon (recon)
   );

   // Keep the last pixel and its upper neighbor
   always_ff @(posedge clock) begin
      if (s1_move) begin
         prev_recon_ff <= recon;
         prev_upper_ff <= upper;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pixel_ff     <= recon;
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_image_end_ff <= s1_image_end_ff;
         rsp_bad_ff       <= (s1_filter_ff > FILT_PAETH);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_pixel_ff[7:0];
   assign rsp_green      = rsp_pixel_ff[15:8];
   assign rsp_blue       = rsp_pixel_ff[23:16];
   assign rsp_alpha      = rsp_pixel_ff[31:24];
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_image_end  = rsp_image_end_ff;
   assign rsp_bad_filter = rsp_bad_ff;

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty read stage");

   a_move_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("moved item did not reach output register");

   a_image_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_image_end_ff |-> rsp_row_end_ff)
      else $error("image end without row end");

   a_fwd_after_move: assert property (@(posedge clock) disable iff (reset)
      accept && s1_move && (s1_col_ff == col_addr) |=> s1_fwd_ff && s1_valid_ff)
      else $error("same-column forward not armed");

endmodule
